FILE: design/lwpf_pkg.sv
// Shared types and constants for the LCD window pixel formatter.
// Used by lwpf_byte_sel, lcd_window_pixel_formatter_core and lwpf_checker.
package lwpf_pkg;

  localparam int COORD_BITS  = 10;
  localparam int PIXEL_BITS  = 16;
  localparam int BURST_BITS  = 6;
  localparam int BURST_LIMIT = 63;
  localparam int LEFT_BITS   = 21;

  localparam logic [LEFT_BITS-1:0] LEFT_MAX = {LEFT_BITS{1'b1}};

  localparam int WINDOW_BYTES = 11;
  localparam int PIXEL_BYTES  = 3;
  localparam int IDX_BITS     = 4;

  // action codes
  localparam logic ACT_WINDOW = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  // controller commands
  localparam logic [7:0] CMD_COL_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] col_first;
    logic [COORD_BITS-1:0] row_first;
    logic [COORD_BITS-1:0] col_final;
    logic [COORD_BITS-1:0] row_final;
    logic [PIXEL_BITS-1:0] pixel_rgb565;
  } req_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  is_data;
    logic                  burst_end;
    logic [BURST_BITS-1:0] burst_bytes;
    logic                  window_done;
    logic                  last;
  } rsp_t;

  // request being serialized, with its burst bookkeeping settled at accept
  typedef struct packed {
    req_t                  item;
    logic                  burst_end;
    logic [BURST_BITS-1:0] burst_bytes;
    logic                  window_done;
  } cur_t;

endpackage

FILE: design/lwpf_byte_sel.sv
// Picks the output byte and its flags for one position of the current request.
// Depends on lwpf_pkg.
module lwpf_byte_sel (
  input  lwpf_pkg::cur_t                 cur,
  input  logic [lwpf_pkg::IDX_BITS-1:0]  idx,
  output lwpf_pkg::rsp_t                 rsp
);

  logic [15:0] c0;
  logic [15:0] c1;
  logic [15:0] r0;
  logic [15:0] r1;
  logic [15:0] pix;
  logic        is_window;

  assign c0  = 16'(cur.item.col_first);
  assign c1  = 16'(cur.item.col_final);
  assign r0  = 16'(cur.item.row_first);
  assign r1  = 16'(cur.item.row_final);
  assign pix = cur.item.pixel_rgb565;
  assign is_window = (cur.item.action == lwpf_pkg::ACT_WINDOW);

  always_comb begin
    rsp = '0;
    rsp.is_data = 1'b1;
    if (is_window) begin
      unique case (idx)
        4'd0: begin
          rsp.out_byte = lwpf_pkg::CMD_COL_SET;
          rsp.is_data  = 1'b0;
        end
        4'd1: rsp.out_byte = c0[15:8];
        4'd2: rsp.out_byte = c0[7:0];
        4'd3: rsp.out_byte = c1[15:8];
        4'd4: rsp.out_byte = c1[7:0];
        4'd5: begin
          rsp.out_byte = lwpf_pkg::CMD_ROW_SET;
          rsp.is_data  = 1'b0;
        end
        4'd6: rsp.out_byte = r0[15:8];
        4'd7: rsp.out_byte = r0[7:0];
        4'd8: rsp.out_byte = r1[15:8];
        4'd9: rsp.out_byte = r1[7:0];
        4'd10: begin
          rsp.out_byte = lwpf_pkg::CMD_MEM_WRITE;
          rsp.is_data  = 1'b0;
          rsp.last     = 1'b1;
        end
        default: rsp.out_byte = '0;
      endcase
    end else begin
      // left-align each channel, zeros below
      unique case (idx)
        4'd0: rsp.out_byte = {pix[15:11], 3'b000};
        4'd1: rsp.out_byte = {pix[10:5], 2'b00};
        4'd2: begin
          rsp.out_byte    = {pix[4:0], 3'b000};
          rsp.burst_end   = cur.burst_end;
          rsp.burst_bytes = cur.burst_end ? cur.burst_bytes : '0;
          rsp.window_done = cur.window_done;
          rsp.last        = 1'b1;
        end
        default: rsp.out_byte = '0;
      endcase
    end
  end

endmodule

FILE: design/lcd_window_pixel_formatter_core.sv
// Top level of the LCD window pixel formatter: accepts window and pixel
// requests and serializes them into command and data bytes.
// Depends on lwpf_pkg and lwpf_byte_sel.
//
//   channel   direction  handshake             payload
//   request   in         req_valid, req_stall  req (lwpf_pkg::req_t)
//   bytes     out        rsp_valid, rsp_stall  rsp (lwpf_pkg::rsp_t)
//
// One output byte per cycle while the output is not stalled, through the single byte
// register feeding the output: a window request yields 11 bytes, a pixel 3.
// The next request is taken in the cycle its predecessor's last byte enters
// the output register.
// A pixel beyond the window's count is taken with no output.
// rst (synchronous) empties both registers and clears the pixel and burst counts.
// An output stall holds the byte register and, through it, the request side.
module lcd_window_pixel_formatter_core #(
  parameter int BURST_LIMIT = lwpf_pkg::BURST_LIMIT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lwpf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lwpf_pkg::rsp_t rsp
);

  localparam int CoordBits = lwpf_pkg::COORD_BITS;
  localparam int SpanBits  = CoordBits + 1;
  localparam int AreaBits  = 2 * SpanBits;
  localparam int LeftBits  = lwpf_pkg::LEFT_BITS;
  localparam int WideBits  = (AreaBits > LeftBits) ? AreaBits : LeftBits;
  localparam int BurstBits = lwpf_pkg::BURST_BITS;
  localparam int IdxBits   = lwpf_pkg::IDX_BITS;

  localparam logic [LeftBits-1:0] LEFT_MAX_W = lwpf_pkg::LEFT_MAX;

  logic                 cur_valid;
  lwpf_pkg::cur_t       cur;
  lwpf_pkg::cur_t       cur_next;
  logic [IdxBits-1:0]   idx;
  logic [IdxBits-1:0]   last_idx;
  logic [LeftBits-1:0]  pixels_left;
  logic [BurstBits-1:0] burst_count;
  lwpf_pkg::rsp_t       rsp_next;

  logic req_take;
  logic rsp_adv;
  logic emit;
  logic emit_last;
  logic req_window;

  // window area
  logic                window_ok;
  logic [SpanBits-1:0] col_span;
  logic [SpanBits-1:0] row_span;
  logic [AreaBits-1:0] area;
  logic [WideBits-1:0] area_wide;
  logic [LeftBits-1:0] area_left;

  // pixel accounting
  logic                 pix_live;
  logic [LeftBits-1:0]  left_dec;
  logic [BurstBits:0]   burst_sum;
  logic                 pix_done;
  logic                 pix_close;

  assign req_take   = req_valid && !req_stall;
  assign rsp_adv    = !rsp_valid || !rsp_stall;
  assign emit       = cur_valid && rsp_adv;
  assign last_idx   = (cur.item.action == lwpf_pkg::ACT_WINDOW) ?
                      IdxBits'(lwpf_pkg::WINDOW_BYTES - 1) :
                      IdxBits'(lwpf_pkg::PIXEL_BYTES - 1);
  assign emit_last  = emit && (idx == last_idx);
  assign req_stall  = cur_valid && !emit_last;
  assign req_window = (req.action == lwpf_pkg::ACT_WINDOW);

  assign window_ok = (req.col_final >= req.col_first) && (req.row_final >= req.row_first);
  assign col_span  = SpanBits'(req.col_final) - SpanBits'(req.col_first) + SpanBits'(1);
  assign row_span  = SpanBits'(req.row_final) - SpanBits'(req.row_first) + SpanBits'(1);
  assign area      = window_ok ? (AreaBits'(col_span) * AreaBits'(row_span)) : '0;
  assign area_wide = WideBits'(area);
  assign area_left = (area_wide > WideBits'(LEFT_MAX_W)) ? lwpf_pkg::LEFT_MAX
                                                        : area_wide[LeftBits-1:0];

  assign pix_live  = (pixels_left != '0);
  assign left_dec  = pixels_left - LeftBits'(1);
  assign burst_sum = {1'b0, burst_count} + (BurstBits+1)'(lwpf_pkg::PIXEL_BYTES);
  assign pix_done  = (left_dec == '0);
  assign pix_close = (burst_sum >= (BurstBits+1)'(BURST_LIMIT)) || pix_done;

  always_comb begin
    cur_next      = '0;
    cur_next.item = req;
    if (!req_window) begin
      cur_next.burst_end   = pix_close;
      cur_next.burst_bytes = burst_sum[BurstBits-1:0];
      cur_next.window_done = pix_done;
    end
  end

  lwpf_byte_sel u_byte_sel (
    .cur (cur),
    .idx (idx),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
      pixels_left <= '0;
      burst_count <= '0;
    end else begin
      if (rsp_adv) begin
        rsp_valid <= cur_valid;
      end
      if (req_take) begin
        if (req_window) begin
          pixels_left <= area_left;
          burst_count <= '0;
          cur_valid   <= 1'b1;
        end else if (pix_live) begin
          pixels_left <= left_dec;
          burst_count <= pix_close ? '0 : burst_sum[BurstBits-1:0];
          cur_valid   <= 1'b1;
        end else begin
          // surplus pixel: drop
          cur_valid <= 1'b0;
        end
      end else if (emit_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cur <= cur_next;
      idx <= '0;
    end else if (emit) begin
      idx <= idx + IdxBits'(1);
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: design/lwpf_checker.sv
// Port-level checks for lcd_window_pixel_formatter_core, attached by bind.
// Depends on lwpf_pkg.
module lwpf_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input lwpf_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input lwpf_pkg::rsp_t rsp
);

  // a stalled byte holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("output byte changed while stalled");

  a_cmd_no_close: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_data |-> !rsp.burst_end && !rsp.window_done)
    else $error("command byte closed a burst");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.window_done |-> rsp.burst_end && rsp.last)
    else $error("window end without burst close");

  a_close_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.burst_end |-> rsp.last && (rsp.burst_bytes != '0)
      || !rsp_valid || !rsp.burst_end)
    else $error("burst close with bad length");

  a_len_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.burst_end |-> (rsp.burst_bytes == '0))
    else $error("burst length outside a close");

endmodule

bind lcd_window_pixel_formatter_core lwpf_checker u_lwpf_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for lcd_window_pixel_formatter_core: directed and random window and
// pixel requests, a byte-exact predictor and an in-order check of every output byte.
// Depends on lwpf_pkg and the formatter RTL.

import lwpf_pkg::*;

class lcd_byte_scoreboard;
  rsp_t                  expected_bytes[$];
  logic [LEFT_BITS-1:0]  pixels_left;
  logic [BURST_BITS-1:0] burst_fill;
  int                    mismatches;

  function new();
    pixels_left = '0;
    burst_fill  = '0;
    mismatches  = 0;
  endfunction

  function void queue_byte(logic [7:0] b, logic data, logic bend,
                           logic [BURST_BITS-1:0] blen, logic wdone, logic lst);
    rsp_t e;
    e.out_byte    = b;
    e.is_data     = data;
    e.burst_end   = bend;
    e.burst_bytes = blen;
    e.window_done = wdone;
    e.last        = lst;
    expected_bytes.push_back(e);
  endfunction

  // Queue the bytes of an accepted request; return how many it produces.
  function int note_request(req_t r);
    int unsigned c0, c1, r0, r1, fill;
    longint unsigned area;
    logic wdone, bend;
    logic [BURST_BITS-1:0] blen;
    if (r.action == ACT_WINDOW) begin
      c0 = r.col_first;
      r0 = r.row_first;
      c1 = r.col_final;
      r1 = r.row_final;
      queue_byte(CMD_COL_SET, 1'b0, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(c0 >> 8), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(c0), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(c1 >> 8), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(c1), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(CMD_ROW_SET, 1'b0, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(r0 >> 8), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(r0), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(r1 >> 8), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(8'(r1), 1'b1, 1'b0, '0, 1'b0, 1'b0);
      queue_byte(CMD_MEM_WRITE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      area = 0;
      // inverted windows leave the count at zero
      if (c1 >= c0 && r1 >= r0)
        area = longint'(c1 - c0 + 1) * longint'(r1 - r0 + 1);
      pixels_left = (area > LEFT_MAX) ? LEFT_MAX : LEFT_BITS'(area);
      burst_fill  = '0;
      return WINDOW_BYTES;
    end
    // drop pixels beyond the window's count
    if (pixels_left == '0)
      return 0;
    pixels_left = pixels_left - 1'b1;
    fill  = burst_fill + PIXEL_BYTES;
    wdone = (pixels_left == '0);
    bend  = (fill >= BURST_LIMIT) || wdone;
    blen  = bend ? BURST_BITS'(fill) : '0;
    burst_fill = bend ? '0 : BURST_BITS'(fill);
    queue_byte({r.pixel_rgb565[15:11], 3'b000}, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    queue_byte({r.pixel_rgb565[10:5], 2'b00}, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    queue_byte({r.pixel_rgb565[4:0], 3'b000}, 1'b1, bend, blen, wdone, 1'b1);
    return PIXEL_BYTES;
  endfunction

  function string describe(rsp_t v);
    return $sformatf("byte %02h data %0b end %0b len %0d done %0b last %0b",
                     v.out_byte, v.is_data, v.burst_end, v.burst_bytes,
                     v.window_done, v.last);
  endfunction

  function void check_byte(rsp_t got);
    rsp_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output byte: %s", describe(got));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
        got.burst_end !== want.burst_end || got.burst_bytes !== want.burst_bytes ||
        got.window_done !== want.window_done || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %s, got %s", describe(want), describe(got));
    end
  endfunction
endclass

module tb;
  localparam int ITEMS       = 180;
  localparam int QUIET_AFTER = 150;
  localparam int CYCLE_LIMIT = 200000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic quiet = 1'b0;
  logic calm  = 1'b0;
  bit   gaps_on = 1'b1;
  int   stall_run = 0;
  int   cycle_count = 0;
  int   useful_items = 0;

  lcd_byte_scoreboard sb;

  lcd_window_pixel_formatter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output stall in random bursts
  always @(posedge clk) begin
    if (quiet || calm) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      rsp_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      stall_run <= $urandom_range(0, 4);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Sample at the falling edge: what is seen here is what the next rising edge takes
  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_byte(rsp);
  end

  // coordinates keep their low COORD_BITS bits
  function automatic req_t window_req(int unsigned c0, int unsigned r0,
                                      int unsigned c1, int unsigned r1);
    logic [63:0] noise;
    req_t w;
    noise = {$urandom, $urandom};
    w = noise[$bits(req_t)-1:0];
    w.action    = ACT_WINDOW;
    w.col_first = COORD_BITS'(c0);
    w.row_first = COORD_BITS'(r0);
    w.col_final = COORD_BITS'(c1);
    w.row_final = COORD_BITS'(r1);
    return w;
  endfunction

  function automatic req_t pixel_req(logic [PIXEL_BITS-1:0] color);
    logic [63:0] noise;
    req_t p;
    noise = {$urandom, $urandom};
    p = noise[$bits(req_t)-1:0];
    p.action       = ACT_PIXEL;
    p.pixel_rgb565 = color;
    return p;
  endfunction

  task automatic drive_request(input req_t r);
    bit taken;
    int produced;
    req       <= r;
    req_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!req_stall) begin
        taken = 1'b1;
        produced = sb.note_request(r);
        if (produced > 0)
          useful_items++;
      end
      @(posedge clk);
    end
    // insert a sender gap now and then
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic run_window_sequence();
    int kind, w, h, c0, r0, c1, area, count;
    kind    = $urandom_range(0, 9);
    gaps_on = ($urandom_range(0, 3) != 0);
    calm   <= ($urandom_range(0, 3) == 0);
    if (kind == 0) begin
      // full-range coordinates: huge or inverted windows, left mostly unfinished
      drive_request(window_req($urandom, $urandom, $urandom, $urandom));
      count = $urandom_range(0, 6);
    end else if (kind == 1) begin
      c0 = $urandom_range(1, 1023);
      c1 = $urandom_range(0, c0 - 1);
      drive_request(window_req(c0, $urandom, c1, $urandom));
      count = $urandom_range(0, 2);
    end else begin
      w  = $urandom_range(1, 8);
      h  = $urandom_range(1, 8);
      c0 = $urandom_range(0, 1024 - w);
      r0 = $urandom_range(0, 1024 - h);
      if ($urandom_range(0, 7) == 0)
        c0 = 1024 - w;
      if ($urandom_range(0, 7) == 0)
        r0 = 0;
      drive_request(window_req(c0, r0, c0 + w - 1, r0 + h - 1));
      area = w * h;
      case ($urandom_range(0, 4))
        0:       count = $urandom_range(0, area - 1);
        1:       count = area + $urandom_range(1, 3);
        default: count = area;
      endcase
    end
    repeat (count) drive_request(pixel_req(PIXEL_BITS'($urandom)));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // inverted columns, then a pixel that is dropped
    drive_request(window_req(10, 0, 9, 5));
    drive_request(pixel_req(16'h1234));
    // inverted rows
    drive_request(window_req(0, 20, 3, 19));
    drive_request(pixel_req(16'hFFFF));
    // single-pixel window, then a surplus pixel
    drive_request(window_req(5, 7, 5, 7));
    drive_request(pixel_req(16'hFFFF));
    drive_request(pixel_req(16'h0000));
    // full screen, a few pixels, then reopen mid-burst
    drive_request(window_req(0, 0, 1023, 1023));
    drive_request(pixel_req(16'h0000));
    drive_request(pixel_req(16'hFFFF));
    drive_request(pixel_req(16'hF800));
    drive_request(pixel_req(16'h07E0));
    drive_request(pixel_req(16'h001F));
    drive_request(window_req(1022, 1023, 1023, 1023));
    drive_request(pixel_req(16'hAAAA));
    drive_request(pixel_req(16'h5555));

    while (useful_items < ITEMS) begin
      if (useful_items >= QUIET_AFTER)
        quiet <= 1'b1;
      run_window_sequence();
    end
    req_valid <= 1'b0;
    quiet     <= 1'b1;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
